// ----- rtl/wah_pkg.sv -----
// Shared types, constants and coefficient tables for the swept biquad wah filter.
`default_nettype none

package wah_pkg;

  localparam int TRIG_TABLE_BITS = 10;
  localparam int SIN_Q           = 1 << (TRIG_TABLE_BITS - 2);
  localparam int SINQ_DEPTH      = SIN_Q + 1;
  localparam int EXP_DEPTH       = (1 << TRIG_TABLE_BITS) + 1;
  localparam int PH_SH           = 32 - TRIG_TABLE_BITS;
  localparam int EXP_SH          = 15 - TRIG_TABLE_BITS;
  localparam int EXP_IDX_W       = TRIG_TABLE_BITS + 1;

  localparam logic [63:0] PI_Q30       = 64'd3373259426;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  localparam int ADDR_W   = 5;
  localparam int DIV_NW   = 52;
  localparam int DIV_DW   = 31;

  localparam logic [31:0] RST_PHASE_STEP      = 32'd146097;
  localparam logic [31:0] RST_START_PHASE     = 32'd0;
  localparam logic [15:0] RST_SWEEP_DEPTH     = 16'd22938;
  localparam logic [15:0] RST_FREQ_OFFSET     = 16'd9830;
  localparam logic [11:0] RST_RESONANCE       = 12'd640;
  localparam logic [7:0]  RST_UPDATE_INTERVAL = 8'd30;

  typedef enum logic [2:0] {
    REG_PHASE_STEP      = 3'd0,
    REG_START_PHASE     = 3'd1,
    REG_SWEEP_DEPTH     = 3'd2,
    REG_FREQ_OFFSET     = 3'd3,
    REG_RESONANCE       = 3'd4,
    REG_UPDATE_INTERVAL = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] phase_step;
    logic [31:0] start_phase;
    logic [15:0] sweep_depth;
    logic [15:0] freq_offset;
    logic [11:0] resonance;
    logic [7:0]  update_interval;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] in_sample;
    logic               start_of_run;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_sample;
    logic               clipped;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIG_RD,
    ST_TRIG_MUL,
    ST_TRIG_FIN,
    ST_G_MUL1,
    ST_G_MUL2,
    ST_F_CALC,
    ST_EXP_RD,
    ST_EXP_MUL,
    ST_EXP_FIN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MAC,
    ST_MAC_ADD,
    ST_FIN
  } core_state_t;

  typedef logic signed [23:0] sinq_rom_t [SINQ_DEPTH];
  typedef logic signed [23:0] exp_rom_t  [EXP_DEPTH];

  function automatic sinq_rom_t build_sinq();
    sinq_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    for (int m = 0; m < SINQ_DEPTH; m++) begin
      x   = (64'd2 * PI_Q30 * 64'(m) + (64'd1 << (TRIG_TABLE_BITS - 1))) >> TRIG_TABLE_BITS;
      x2  = (x * x) >> 30;
      mag = x;
      sum = $signed(x);
      for (int n = 1; n <= 7; n++) begin
        mag = ((mag * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n[0]) sum = sum - $signed(mag);
        else      sum = sum + $signed(mag);
      end
      rom[m] = 24'((sum + 64'sd128) >>> 8);
    end
    return rom;
  endfunction

  function automatic exp_rom_t build_exp();
    exp_rom_t           rom;
    logic [63:0]        y;
    logic [63:0]        z;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    logic [63:0]        s;
    for (int i = 0; i < EXP_DEPTH; i++) begin
      y   = ((64'd6 << 30) * 64'(i)) >> TRIG_TABLE_BITS;
      z   = y >> 4;
      mag = 64'd1 << 30;
      sum = 64'sd1 <<< 30;
      for (int n = 1; n <= 8; n++) begin
        mag = ((mag * z) >> 30) / 64'(n);
        if (n[0]) sum = sum - $signed(mag);
        else      sum = sum + $signed(mag);
      end
      s = (sum < 0) ? 64'd0 : $unsigned(sum);
      for (int n = 0; n < 4; n++) s = (s * s) >> 30;
      rom[i] = 24'((s + 64'd128) >> 8);
    end
    return rom;
  endfunction

  localparam sinq_rom_t SINQ_ROM = build_sinq();
  localparam exp_rom_t  EXP_ROM  = build_exp();

endpackage

`default_nettype wire

// ----- rtl/wah_regs.sv -----
// APB register file holding the filter configuration.
`default_nettype none

module wah_regs
  import wah_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step      <= RST_PHASE_STEP;
      cfg.start_phase     <= RST_START_PHASE;
      cfg.sweep_depth     <= RST_SWEEP_DEPTH;
      cfg.freq_offset     <= RST_FREQ_OFFSET;
      cfg.resonance       <= RST_RESONANCE;
      cfg.update_interval <= RST_UPDATE_INTERVAL;
    end else if (wr) begin
      case (idx)
        REG_PHASE_STEP:      cfg.phase_step      <= pwdata;
        REG_START_PHASE:     cfg.start_phase     <= pwdata;
        REG_SWEEP_DEPTH:     cfg.sweep_depth     <= pwdata[15:0];
        REG_FREQ_OFFSET:     cfg.freq_offset     <= pwdata[15:0];
        REG_RESONANCE:       cfg.resonance       <= pwdata[11:0];
        REG_UPDATE_INTERVAL: cfg.update_interval <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PHASE_STEP:      prdata = cfg.phase_step;
      REG_START_PHASE:     prdata = cfg.start_phase;
      REG_SWEEP_DEPTH:     prdata = 32'(cfg.sweep_depth);
      REG_FREQ_OFFSET:     prdata = 32'(cfg.freq_offset);
      REG_RESONANCE:       prdata = 32'(cfg.resonance);
      REG_UPDATE_INTERVAL: prdata = 32'(cfg.update_interval);
      default:             prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/wah_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module wah_div
  import wah_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_DW:0]   rem;
  logic [DIV_NW-1:0] dvd;
  logic [DIV_DW-1:0] dsr;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW+1:0] diff;

  assign rem_sh = {rem[DIV_DW-1:0], dvd[DIV_NW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      if (!diff[DIV_DW+1]) begin
        rem <= diff[DIV_DW:0];
        dvd <= {dvd[DIV_NW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        dvd <= {dvd[DIV_NW-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

`default_nettype wire

// ----- rtl/wah_core.sv -----
// Sequencer and shared multiply-accumulate datapath for coefficients and filtering.
`default_nettype none

module wah_core
  import wah_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire logic     sample_valid,
  output logic          sample_ready,
  input  wire in_item_t sample,
  output logic          result_valid,
  input  wire logic     result_ready,
  output out_item_t     result
);

  localparam int SINQ_W = TRIG_TABLE_BITS - 1;

  typedef enum logic [1:0] {TRIG_LFO, TRIG_SIN, TRIG_COS} trig_sel_t;
  typedef enum logic [2:0] {DIV_ALPHA, DIV_B0, DIV_B1, DIV_A1, DIV_A2} div_sel_t;

  function automatic logic signed [23:0] sin_lookup(input logic [TRIG_TABLE_BITS-1:0] idx);
    logic [1:0]         q;
    logic [SINQ_W-1:0]  j;
    logic [SINQ_W-1:0]  m;
    logic signed [23:0] v;
    q = idx[TRIG_TABLE_BITS-1 -: 2];
    j = SINQ_W'(idx[TRIG_TABLE_BITS-3:0]);
    m = q[0] ? (SINQ_W'(SIN_Q) - j) : j;
    v = SINQ_ROM[m];
    return q[1] ? -v : v;
  endfunction

  function automatic logic signed [23:0] qsat(input logic [DIV_NW-1:0] m, input logic neg);
    if (!neg) return (m > DIV_NW'(8388607)) ? 24'sh7fffff : $signed(m[23:0]);
    return (m > DIV_NW'(8388608)) ? 24'sh800000 : -$signed(m[23:0]);
  endfunction

  core_state_t state, state_next;
  trig_sel_t   tsel;
  div_sel_t    dsel;
  logic [2:0]  mac_cnt;

  logic signed [15:0] x_cur, x_hist_1, x_hist_2;
  logic signed [23:0] y_hist_1, y_hist_2;
  logic [31:0]        lfo_phase, ph_work;
  logic [7:0]         icnt;
  logic signed [23:0] coef_b0, coef_b1, coef_a1, coef_a2;

  logic signed [23:0]  trig_a, trig_b;
  logic [PH_SH-1:0]    trig_fr;
  logic signed [24:0]  cos_v, cs;
  logic [23:0]         sn;
  logic signed [63:0]  prod, acc;
  logic [EXP_IDX_W-1:0] exp_idx;
  logic [EXP_SH-1:0]   exp_fr;
  logic signed [23:0]  e0, e1;
  logic [23:0]         e_val;
  logic [31:0]         alpha;
  logic                q_neg;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic [7:0]  icnt_w, icnt_inc, icnt_nx;
  logic        need_coef;
  logic        out_go;

  logic [31:0]                trig_phase, e_ph;
  logic [TRIG_TABLE_BITS-1:0] trig_idx, trig_idx_b;
  logic signed [63:0]         trig_rnd;
  logic signed [24:0]         trig_val;
  logic signed [31:0]         g_sum, g15;
  logic signed [63:0]         f_wide;
  logic [15:0]                f_cl, u_val;
  logic [EXP_IDX_W-1:0]       exp_idx_b;
  logic signed [63:0]         e_rnd;
  logic signed [23:0]         e_int;
  logic [11:0]                r_eff;
  logic [30:0]                a0;
  logic signed [33:0]         qx;
  logic [32:0]                qmag;
  logic signed [63:0]         y_full;

  wah_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign icnt_w    = sample.start_of_run ? 8'd0 : icnt;
  assign icnt_inc  = icnt_w + 8'd1;
  assign icnt_nx   = (icnt_inc >= cfg.update_interval) ? 8'd0 : icnt_inc;
  assign need_coef = (icnt_w == 8'd0);
  assign out_go    = !result_valid || result_ready;

  assign e_ph = {e_val[22:0], 9'b0};
  always_comb begin
    unique case (tsel)
      TRIG_LFO: trig_phase = ph_work + QUARTER_TURN;
      TRIG_SIN: trig_phase = e_ph;
      TRIG_COS: trig_phase = e_ph + QUARTER_TURN;
      default:  trig_phase = ph_work;
    endcase
  end
  assign trig_idx   = trig_phase[31:PH_SH];
  assign trig_idx_b = trig_idx + TRIG_TABLE_BITS'(1);
  assign trig_rnd   = (prod + (64'sd1 <<< (PH_SH - 1))) >>> PH_SH;
  assign trig_val   = 25'(trig_a) + trig_rnd[24:0];

  assign g_sum = 32'sd4194304 + 32'(cos_v) + 32'sd128;
  assign g15   = g_sum >>> 8;

  assign f_wide = ((prod + 64'sd536870912) >>> 30) + $signed(64'(cfg.freq_offset));
  always_comb begin
    priority if (f_wide < 0)              f_cl = 16'd0;
    else if (f_wide > 64'sd32768)         f_cl = 16'd32768;
    else                                  f_cl = f_wide[15:0];
  end
  assign u_val     = 16'd32768 - f_cl;
  assign exp_idx_b = (exp_idx == EXP_IDX_W'(EXP_DEPTH - 1)) ? exp_idx : exp_idx + 1'b1;
  assign e_rnd     = (prod + (64'sd1 <<< (EXP_SH - 1))) >>> EXP_SH;
  assign e_int     = (exp_fr != '0) ? e0 + e_rnd[23:0] : e0;

  assign r_eff = (cfg.resonance == 12'd0) ? 12'd1 : cfg.resonance;
  assign a0    = 31'(32'd4194304 + alpha);
  always_comb begin
    unique case (dsel)
      DIV_B0, DIV_B1: qx = 34'sd4194304 - 34'(cs);
      DIV_A1:         qx = -(34'(cs) <<< 1);
      DIV_A2:         qx = 34'sd4194304 - $signed(34'(alpha));
      default:        qx = 34'sd0;
    endcase
  end
  assign qmag = qx[33] ? 33'(-qx) : 33'(qx);

  always_comb begin
    div_req.start = (state == ST_DIV_START);
    unique case (dsel)
      DIV_ALPHA: div_req.divisor = 31'(r_eff);
      DIV_B0:    div_req.divisor = {a0[29:0], 1'b0};
      default:   div_req.divisor = a0;
    endcase
    if (dsel == DIV_ALPHA)
      div_req.dividend = DIV_NW'({sn, 7'b0}) + DIV_NW'(r_eff >> 1);
    else
      div_req.dividend = DIV_NW'({qmag, 22'b0}) + DIV_NW'(div_req.divisor >> 1);
  end

  assign y_full = (acc + 64'sd2097152) >>> 22;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (sample_valid) state_next = need_coef ? ST_TRIG_RD : ST_MAC;
      ST_TRIG_RD:   state_next = ST_TRIG_MUL;
      ST_TRIG_MUL:  state_next = ST_TRIG_FIN;
      ST_TRIG_FIN: begin
        unique case (tsel)
          TRIG_LFO: state_next = ST_G_MUL1;
          TRIG_SIN: state_next = ST_TRIG_RD;
          default:  state_next = ST_DIV_START;
        endcase
      end
      ST_G_MUL1:    state_next = ST_G_MUL2;
      ST_G_MUL2:    state_next = ST_F_CALC;
      ST_F_CALC:    state_next = ST_EXP_RD;
      ST_EXP_RD:    state_next = ST_EXP_MUL;
      ST_EXP_MUL:   state_next = ST_EXP_FIN;
      ST_EXP_FIN:   state_next = ST_TRIG_RD;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_rsp.done) state_next = (dsel == DIV_A2) ? ST_MAC : ST_DIV_START;
      ST_MAC:       if (mac_cnt == 3'd4) state_next = ST_MAC_ADD;
      ST_MAC_ADD:   state_next = ST_FIN;
      ST_FIN:       if (out_go) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample_ready  = (state == ST_IDLE);
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    unique case (state)
      ST_TRIG_MUL: begin
        mul_a = 32'(trig_b) - 32'(trig_a);
        mul_b = $signed(32'(trig_fr));
      end
      ST_G_MUL1: begin
        mul_a = g15;
        mul_b = $signed(32'(cfg.sweep_depth));
      end
      ST_G_MUL2: begin
        mul_a = $signed(prod[31:0]);
        mul_b = 32'sd32768 - $signed(32'(cfg.freq_offset));
      end
      ST_EXP_MUL: begin
        mul_a = 32'(e1) - 32'(e0);
        mul_b = $signed(32'(exp_fr));
      end
      ST_MAC: begin
        unique case (mac_cnt)
          3'd0:    begin mul_a = 32'(coef_b0);  mul_b = 32'(x_cur);    end
          3'd1:    begin mul_a = 32'(coef_b1);  mul_b = 32'(x_hist_1); end
          3'd2:    begin mul_a = 32'(coef_b0);  mul_b = 32'(x_hist_2); end
          3'd3:    begin mul_a = -32'(coef_a1); mul_b = 32'(y_hist_1); end
          default: begin mul_a = -32'(coef_a2); mul_b = 32'(y_hist_2); end
        endcase
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_hist_1     <= '0;
      x_hist_2     <= '0;
      y_hist_1     <= '0;
      y_hist_2     <= '0;
      lfo_phase    <= RST_START_PHASE + RST_PHASE_STEP;
      icnt         <= '0;
      coef_b0      <= '0;
      coef_b1      <= '0;
      coef_a1      <= '0;
      coef_a2      <= '0;
      result_valid <= 1'b0;
      tsel         <= TRIG_LFO;
      dsel         <= DIV_ALPHA;
      mac_cnt      <= '0;
    end else begin
      if (result_ready && state != ST_FIN) result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            x_cur   <= sample.in_sample;
            icnt    <= icnt_nx;
            tsel    <= TRIG_LFO;
            dsel    <= DIV_ALPHA;
            mac_cnt <= '0;
            if (sample.start_of_run) begin
              x_hist_1  <= '0;
              x_hist_2  <= '0;
              y_hist_1  <= '0;
              y_hist_2  <= '0;
              ph_work   <= cfg.start_phase + cfg.phase_step;
              lfo_phase <= cfg.start_phase + cfg.phase_step + cfg.phase_step;
            end else begin
              ph_work   <= lfo_phase;
              lfo_phase <= lfo_phase + cfg.phase_step;
            end
          end
        end
        ST_TRIG_RD: begin
          trig_a  <= sin_lookup(trig_idx);
          trig_b  <= sin_lookup(trig_idx_b);
          trig_fr <= trig_phase[PH_SH-1:0];
        end
        ST_TRIG_MUL, ST_G_MUL1, ST_G_MUL2, ST_EXP_MUL: prod <= mul_p;
        ST_TRIG_FIN: begin
          unique case (tsel)
            TRIG_LFO: cos_v <= trig_val;
            TRIG_SIN: begin
              sn   <= trig_val[24] ? 24'd0 : trig_val[23:0];
              tsel <= TRIG_COS;
            end
            default:  cs <= trig_val;
          endcase
        end
        ST_F_CALC: begin
          exp_idx <= u_val[15:EXP_SH];
          exp_fr  <= u_val[EXP_SH-1:0];
        end
        ST_EXP_RD: begin
          e0 <= EXP_ROM[exp_idx];
          e1 <= EXP_ROM[exp_idx_b];
        end
        ST_EXP_FIN: begin
          e_val <= e_int[23] ? 24'd0 : e_int;
          tsel  <= TRIG_SIN;
        end
        ST_DIV_START: q_neg <= qx[33];
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            unique case (dsel)
              DIV_ALPHA: alpha   <= div_rsp.quotient[31:0];
              DIV_B0:    coef_b0 <= qsat(div_rsp.quotient, q_neg);
              DIV_B1:    coef_b1 <= qsat(div_rsp.quotient, q_neg);
              DIV_A1:    coef_a1 <= qsat(div_rsp.quotient, q_neg);
              default:   coef_a2 <= qsat(div_rsp.quotient, q_neg);
            endcase
            if (dsel != DIV_A2) dsel <= div_sel_t'(dsel + 3'd1);
          end
        end
        ST_MAC: begin
          prod    <= mul_p;
          acc     <= (mac_cnt == 3'd0) ? 64'sd0 : acc + prod;
          mac_cnt <= mac_cnt + 3'd1;
        end
        ST_MAC_ADD: acc <= acc + prod;
        ST_FIN: begin
          if (out_go) begin
            result_valid <= 1'b1;
            x_hist_2     <= x_hist_1;
            x_hist_1     <= x_cur;
            y_hist_2     <= y_hist_1;
            priority if (y_full > 64'sd8388607)  y_hist_1 <= 24'sh7fffff;
            else if (y_full < -64'sd8388608)     y_hist_1 <= 24'sh800000;
            else                                 y_hist_1 <= y_full[23:0];
            priority if (y_full > 64'sd32767) begin
              result.out_sample <= 16'sh7fff;
              result.clipped    <= 1'b1;
            end else if (y_full < -64'sd32768) begin
              result.out_sample <= 16'sh8000;
              result.clipped    <= 1'b1;
            end else begin
              result.out_sample <= y_full[15:0];
              result.clipped    <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_done_adv: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_WAIT && div_rsp.done) |=> (state == ST_DIV_START || state == ST_MAC))
    else $error("sequencer missed divider completion");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> !sample_ready)
    else $error("item taken while previous still in work");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_go) |=> result_valid)
    else $error("finished item not presented");

endmodule

`default_nettype wire

// ----- rtl/lfo_swept_biquad_wah_filter_unit.sv -----
// Top level of the LFO swept biquad wah filter.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+--------------------------------
//  sample    | sample_valid / sample_ready  | in_sample, start_of_run
//  result    | result_valid / result_ready  | out_sample, clipped
//  config    | psel penable pwrite pready   | paddr, pwdata, prdata
//
//  A sample that reuses the current coefficients passes through five MAC
//  steps on the shared multiplier, a final add and the output load.
//  A coefficient refresh adds five divisions on the bit-serial divider
//  plus 15 table and multiply steps.
//  Reset is synchronous; no clearing pass is needed. The result register lets
//  the next sample enter while a finished one waits; a stalled result holds
//  the block in its last step until the slot frees.
`default_nettype none

module lfo_swept_biquad_wah_filter_unit
  import wah_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  output logic                   sample_ready,
  input  wire in_item_t          sample,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output out_item_t              result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  cfg_t cfg;

  wah_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wah_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire
